/* hdl/dhsc_pkg.sv */
// ----------------------------------------------------------------------------
// dhsc_pkg: shared types and functions for the duplicated SECDED byte codec
// Extended Hamming(8,4) encode and check functions, status and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dhsc_pkg;

  localparam logic [3:0] NIB_MASK  = 4'hf;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  typedef enum logic [0:0] {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_FIXED  = 2'd1,
    ST_SECOND = 2'd2,
    ST_BOTH   = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       dbl;
    logic       fixed;
  } check_t;

  function automatic logic [7:0] make_cw(input logic [3:0] nib);
    logic [6:0] low7;
    low7 = {nib[0] ^ nib[2] ^ nib[3],
            nib[0] ^ nib[1] ^ nib[3],
            nib[0] ^ nib[1] ^ nib[2],
            nib & NIB_MASK};
    return {^low7, low7};
  endfunction

  // Only data bits matter for the nibble, so only flips of bits 0-3 are applied.
  function automatic check_t check_cw(input logic [7:0] cw);
    logic   s1;
    logic   s2;
    logic   s3;
    logic   par;
    check_t res;
    s1  = cw[0] ^ cw[1] ^ cw[2] ^ cw[4];
    s2  = cw[0] ^ cw[1] ^ cw[3] ^ cw[5];
    s3  = cw[0] ^ cw[2] ^ cw[3] ^ cw[6];
    par = ^cw;
    res.nib    = cw[3:0] ^ ({4{par}} & {~s1 & s2 & s3,
                                        s1 & ~s2 & s3,
                                        s1 & s2 & ~s3,
                                        s1 & s2 & s3});
    res.fixed  = par;
    res.dbl    = ~par & (s1 | s2 | s3);
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/dhsc_pair_dec.sv */
// ----------------------------------------------------------------------------
// dhsc_pair_dec: decoder for one duplicated codeword pair
// Checks the first copy; on a double error falls back to the second copy.
// ----------------------------------------------------------------------------
`default_nettype none

module dhsc_pair_dec (
  input  wire logic [7:0]       first_cw,
  input  wire logic [7:0]       second_cw,
  output logic [3:0]            nib,
  output dhsc_pkg::status_t     status
);

  dhsc_pkg::check_t chk_a;
  dhsc_pkg::check_t chk_b;

  always_comb begin
    chk_a = dhsc_pkg::check_cw(first_cw);
    chk_b = dhsc_pkg::check_cw(second_cw);
    if (!chk_a.dbl) begin
      nib    = chk_a.nib;
      status = chk_a.fixed ? dhsc_pkg::ST_FIXED : dhsc_pkg::ST_CLEAN;
    end else begin
      nib    = chk_b.nib;
      status = chk_b.dbl ? dhsc_pkg::ST_BOTH : dhsc_pkg::ST_SECOND;
    end
  end

endmodule

`default_nettype wire

/* hdl/duplicated_hamming_secded_codec_top.sv */
// ----------------------------------------------------------------------------
// duplicated_hamming_secded_codec_top: duplicated SECDED byte codec
// Encodes a byte into two copies of two Hamming(8,4) codewords, or decodes
// such a word with single-error correction and fallback to the second copy.
//
//   channel | ports                                    | direction
//   in      | in_valid/in_ready, action, data, code    | input transfer
//   out     | out_valid/out_ready, word, byte, status  | result transfer
//
// Two register stages: input register, then result register; the XOR check logic
// sits between them. One transfer per cycle sustained while out_ready stays high.
// Synchronous active-low reset clears both stage valid flags.
// A stalled output holds its result while the input register can still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module duplicated_hamming_secded_codec_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [31:0] in_code_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_encoded_word,
  output logic [7:0]       out_decoded_byte,
  output logic [1:0]       out_high_status,
  output logic [1:0]       out_low_status
);

  logic        s1_valid_r;
  logic        s1_action_r;
  logic [7:0]  s1_data_r;
  logic [31:0] s1_code_r;

  logic        out_valid_r;
  logic [31:0] enc_r;
  logic [7:0]  dec_r;
  logic [1:0]  hst_r;
  logic [1:0]  lst_r;

  logic        out_load;
  logic        s1_load;

  logic [7:0]  cw_hi;
  logic [7:0]  cw_lo;
  logic [3:0]  hi_nib;
  logic [3:0]  lo_nib;
  dhsc_pkg::status_t hi_st;
  dhsc_pkg::status_t lo_st;

  logic [31:0] enc_nxt;
  logic [7:0]  dec_nxt;
  logic [1:0]  hst_nxt;
  logic [1:0]  lst_nxt;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load) begin
      s1_action_r <= in_action;
      s1_data_r   <= in_data_byte;
      s1_code_r   <= in_code_word;
    end
  end

  dhsc_pair_dec u_hi_dec (
    .first_cw  (s1_code_r[7:0]),
    .second_cw (s1_code_r[15:8]),
    .nib       (hi_nib),
    .status    (hi_st)
  );

  dhsc_pair_dec u_lo_dec (
    .first_cw  (s1_code_r[23:16]),
    .second_cw (s1_code_r[31:24]),
    .nib       (lo_nib),
    .status    (lo_st)
  );

  always_comb begin
    cw_hi = dhsc_pkg::make_cw(s1_data_r[7:4]);
    cw_lo = dhsc_pkg::make_cw(s1_data_r[3:0]);
    if (s1_action_r == dhsc_pkg::ACT_ENCODE) begin
      enc_nxt = {cw_lo, cw_lo, cw_hi, cw_hi};
      dec_nxt = 8'd0;
      hst_nxt = dhsc_pkg::ST_CLEAN;
      lst_nxt = dhsc_pkg::ST_CLEAN;
    end else begin
      enc_nxt = 32'd0;
      dec_nxt = {hi_nib, lo_nib};
      hst_nxt = hi_st;
      lst_nxt = lo_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_load) begin
      enc_r <= enc_nxt;
      dec_r <= dec_nxt;
      hst_r <= hst_nxt;
      lst_r <= lst_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_encoded_word = enc_r;
  assign out_decoded_byte = dec_r;
  assign out_high_status  = hst_r;
  assign out_low_status   = lst_r;

`ifndef SYNTH
  a_encode_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_encoded_word != 32'd0) |->
      (out_decoded_byte == 8'd0 && out_high_status == dhsc_pkg::ST_CLEAN &&
       out_low_status == dhsc_pkg::ST_CLEAN))
    else $error("encode transfer carries decode fields");

  a_copies_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_encoded_word[7:0] == out_encoded_word[15:8] &&
                   out_encoded_word[23:16] == out_encoded_word[31:24]))
    else $error("encoded copies differ");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=>
      (s1_valid_r && $stable(s1_code_r) && $stable(s1_data_r) &&
       $stable(s1_action_r)))
    else $error("input register lost a stalled item");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("empty input register not ready");
`endif

endmodule

`default_nettype wire

/* sim/tb_duplicated_hamming_secded_codec_top.sv */
// ----------------------------------------------------------------------------
// tb_duplicated_hamming_secded_codec_top: testbench for the duplicated SECDED codec
// Directed and random encode/decode transfers with random gaps on both channels.
// Every accepted transfer is predicted by an independent extended Hamming(8,4)
// model and checked field by field against the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_duplicated_hamming_secded_codec_top;

  localparam int NUM_RANDOM       = 1350;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES      = 10;

  typedef struct {
    logic              drain;
    dhsc_pkg::action_t act;
    logic [7:0]        data;
    logic [31:0]       code;
  } codec_req_t;

  typedef struct {
    logic [31:0]       enc;
    logic [7:0]        dec_byte;
    dhsc_pkg::status_t hs;
    dhsc_pkg::status_t ls;
  } codec_res_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       dbl;
    logic       fixed;
  } cw_check_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  dhsc_pkg::action_t in_action = dhsc_pkg::ACT_ENCODE;
  logic [7:0]        in_data_byte = '0;
  logic [31:0]       in_code_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_encoded_word;
  logic [7:0]        out_decoded_byte;
  logic [1:0]        out_high_status;
  logic [1:0]        out_low_status;

  codec_req_t  pending_q[$];
  codec_res_t  expected_q[$];
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int          result_cnt = 0;
  int          sent_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  logic        long_hold_done = 1'b0;

  duplicated_hamming_secded_codec_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_data_byte     (in_data_byte),
    .in_code_word     (in_code_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_encoded_word (out_encoded_word),
    .out_decoded_byte (out_decoded_byte),
    .out_high_status  (out_high_status),
    .out_low_status   (out_low_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] hamming_cw(input logic [3:0] n);
    logic [6:0] l7;
    l7 = {n[0] ^ n[2] ^ n[3], n[0] ^ n[1] ^ n[3], n[0] ^ n[1] ^ n[2], n};
    return {^l7, l7};
  endfunction

  function automatic cw_check_t check_copy(input logic [7:0] cw);
    logic [2:0] syn;
    int         pos;
    cw_check_t  r;
    syn = {cw[0] ^ cw[2] ^ cw[3] ^ cw[6],
           cw[0] ^ cw[1] ^ cw[3] ^ cw[5],
           cw[0] ^ cw[1] ^ cw[2] ^ cw[4]};
    r.dbl   = 1'b0;
    r.fixed = 1'b0;
    if (^cw) begin
      case (syn)
        3'b111:  pos = 0;
        3'b011:  pos = 1;
        3'b101:  pos = 2;
        3'b110:  pos = 3;
        3'b001:  pos = 4;
        3'b010:  pos = 5;
        3'b100:  pos = 6;
        default: pos = 7;
      endcase
      cw      = cw ^ (8'h01 << pos);
      r.fixed = 1'b1;
    end else if (syn != 3'b000) begin
      r.dbl = 1'b1;
    end
    r.nib = cw[3:0];
    return r;
  endfunction

  function automatic logic [3:0] decode_copies(input logic [7:0] first,
                                               input logic [7:0] second,
                                               output dhsc_pkg::status_t st);
    cw_check_t c;
    c = check_copy(first);
    if (!c.dbl) begin
      st = c.fixed ? dhsc_pkg::ST_FIXED : dhsc_pkg::ST_CLEAN;
      return c.nib;
    end
    c  = check_copy(second);
    st = c.dbl ? dhsc_pkg::ST_BOTH : dhsc_pkg::ST_SECOND;
    return c.nib;
  endfunction

  function automatic codec_res_t predict_codec(input dhsc_pkg::action_t act,
                                               input logic [7:0] d,
                                               input logic [31:0] w);
    codec_res_t r;
    logic [7:0] hi;
    logic [7:0] lo;
    r.enc      = '0;
    r.dec_byte = '0;
    r.hs       = dhsc_pkg::ST_CLEAN;
    r.ls       = dhsc_pkg::ST_CLEAN;
    if (act == dhsc_pkg::ACT_ENCODE) begin
      hi    = hamming_cw(d[7:4]);
      lo    = hamming_cw(d[3:0]);
      r.enc = {lo, lo, hi, hi};
    end else begin
      r.dec_byte[7:4] = decode_copies(w[7:0], w[15:8], r.hs);
      r.dec_byte[3:0] = decode_copies(w[23:16], w[31:24], r.ls);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic logic [31:0] stored_word(input logic [7:0] h1, input logic [7:0] h2,
                                              input logic [7:0] l1, input logic [7:0] l2);
    return {l2, l1, h2, h1};
  endfunction

  // 0 clean, 1 one flip, 2 two flips, 3 arbitrary byte
  function automatic logic [7:0] damaged_cw(input logic [3:0] n, input int mode);
    logic [7:0] cw;
    int         i;
    int         j;
    cw = hamming_cw(n);
    i  = $urandom_range(0, 7);
    j  = (i + $urandom_range(1, 7)) % 8;
    case (mode)
      1:       cw = cw ^ (8'h01 << i);
      2:       cw = cw ^ (8'h01 << i) ^ (8'h01 << j);
      3:       cw = 8'($urandom_range(0, 255));
      default: ;
    endcase
    return cw;
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 6) return 1;
    if (r < 9) return 2;
    return 3;
  endfunction

  function automatic int draw_wait(input int count);
    if ((count / 80) % 3 == 0) return 0;
    return $urandom_range(0, 5);
  endfunction

  task automatic add_item(input dhsc_pkg::action_t act, input logic [7:0] d,
                          input logic [31:0] w);
    codec_req_t q;
    q.drain = 1'b0;
    q.act   = act;
    q.data  = d;
    q.code  = w;
    pending_q.push_back(q);
  endtask

  task automatic add_drain();
    codec_req_t q;
    q.drain = 1'b1;
    q.act   = dhsc_pkg::ACT_ENCODE;
    q.data  = '0;
    q.code  = '0;
    pending_q.push_back(q);
  endtask

  task automatic field_mismatch(input string fld, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, exp_v, got_v);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    logic       busy;
    codec_req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && !in_taken;
      if (in_taken) begin
        send_gap = draw_wait(sent_cnt);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && pending_q[0].drain) begin
          if (expected_q.size() == 0 && !in_taken) begin
            void'(pending_q.pop_front());
          end
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          q = pending_q.pop_front();
          in_action    <= q.act;
          in_data_byte <= q.data;
          in_code_word <= q.code;
          in_valid     <= 1'b1;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if (!long_hold_done && result_cnt >= LONG_HOLD_AT) begin
          recv_stall     = LONG_HOLD_CYCLES;
          long_hold_done = 1'b1;
        end else begin
          recv_stall = draw_wait(result_cnt + 40);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    codec_res_t e;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        result_cnt <= result_cnt + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual word %h byte %h",
                   $time, out_encoded_word, out_decoded_byte);
          err_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (out_encoded_word !== e.enc)
            field_mismatch("encoded_word", e.enc, out_encoded_word);
          if (out_decoded_byte !== e.dec_byte)
            field_mismatch("decoded_byte", 32'(e.dec_byte), 32'(out_decoded_byte));
          if (out_high_status !== e.hs)
            field_mismatch("high_status", 32'(e.hs), 32'(out_high_status));
          if (out_low_status !== e.ls)
            field_mismatch("low_status", 32'(e.ls), 32'(out_low_status));
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_codec(in_action, in_data_byte, in_code_word));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [7:0]  g;
    logic [31:0] w;
    logic [3:0]  hn;
    logic [3:0]  ln;

    add_item(dhsc_pkg::ACT_ENCODE, 8'h00, 32'h0000_0000);
    add_item(dhsc_pkg::ACT_ENCODE, 8'hff, 32'h0000_0000);
    add_item(dhsc_pkg::ACT_ENCODE, 8'ha5, 32'hffff_ffff);
    add_item(dhsc_pkg::ACT_ENCODE, 8'h3c, 32'h1234_5678);
    add_item(dhsc_pkg::ACT_DECODE, 8'h00, 32'h0000_0000);
    add_item(dhsc_pkg::ACT_DECODE, 8'h00, 32'hffff_ffff);
    w = stored_word(hamming_cw(4'h9), hamming_cw(4'h9), hamming_cw(4'h6), hamming_cw(4'h6));
    add_item(dhsc_pkg::ACT_DECODE, 8'hff, w);
    // single error in each bit of both first copies, overall parity bit included
    for (int b = 0; b < 8; b++) begin
      w = stored_word(hamming_cw(4'hb), hamming_cw(4'hb), hamming_cw(4'h4), hamming_cw(4'h4));
      w = w ^ (32'h1 << b) ^ (32'h1 << (16 + 7 - b));
      add_item(dhsc_pkg::ACT_DECODE, 8'h00, w);
    end
    // double error in first copy, second clean / corrected / also double; last one has a clean low first copy
    g = hamming_cw(4'h7);
    add_item(dhsc_pkg::ACT_DECODE, 8'h00, stored_word(g ^ 8'h03, g, g ^ 8'h81, g));
    add_item(dhsc_pkg::ACT_DECODE, 8'h00,
             stored_word(g ^ 8'h30, g ^ 8'h04, g ^ 8'h0c, g ^ 8'h80));
    add_item(dhsc_pkg::ACT_DECODE, 8'h00,
             stored_word(g ^ 8'h11, g ^ 8'h22, g ^ 8'h05, g ^ 8'h60));
    add_item(dhsc_pkg::ACT_DECODE, 8'h00, stored_word(g ^ 8'hc0, g ^ 8'h09, g, g ^ 8'h06));
    add_item(dhsc_pkg::ACT_DECODE, 8'h5a, 32'hdead_beef);
    add_item(dhsc_pkg::ACT_DECODE, 8'h00, 32'h8000_0080);
    add_drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) add_drain();
      hn = 4'($urandom_range(0, 15));
      ln = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 3) begin
        add_item(dhsc_pkg::ACT_ENCODE, 8'($urandom_range(0, 255)), 32'($urandom));
      end else if ($urandom_range(0, 19) == 0) begin
        add_item(dhsc_pkg::ACT_DECODE, 8'($urandom_range(0, 255)), 32'($urandom));
      end else begin
        w = stored_word(damaged_cw(hn, pick_mode()),
                        damaged_cw($urandom_range(0, 3) == 0 ? ~hn : hn, pick_mode()),
                        damaged_cw(ln, pick_mode()),
                        damaged_cw($urandom_range(0, 3) == 0 ? ~ln : ln, pick_mode()));
        add_item(dhsc_pkg::ACT_DECODE, 8'($urandom_range(0, 255)), w);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || in_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* duplicated_hamming_secded_codec_top.f */
hdl/dhsc_pkg.sv
hdl/dhsc_pair_dec.sv
hdl/duplicated_hamming_secded_codec_top.sv
sim/tb_duplicated_hamming_secded_codec_top.sv
